// ===== design/rsa_modexp_sign_verify_unit_defines.svh =====
// Assertion macros shared by the RSA modular exponentiation RTL.
`ifndef RSA_MODEXP_SIGN_VERIFY_UNIT_DEFINES_SVH
`define RSA_MODEXP_SIGN_VERIFY_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSAMV_ASSERT_IMP(label, clk, rst, ante, cons, text) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(text);

// Next-cycle implication, checked on every rising edge outside reset.
`define RSAMV_ASSERT_NXT(label, clk, rst, ante, cons, text) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(text);

`endif

// ===== design/rsamv_pkg.sv =====
// Shared constants and types for the RSA modular exponentiation unit.
`default_nettype none

package rsamv_pkg;

   // Port field widths.
   localparam int FIELD_W = 64;
   // Operand width used by the arithmetic (8 to 64).
   localparam int OPW     = 64;
   // Bit counter width, able to hold OPW itself.
   localparam int CNT_W   = $clog2(OPW + 1);
   // Configuration index width.
   localparam int CSR_W   = 2;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_W-1:0] CSR_PRIVATE_EXPONENT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_PUBLIC_EXPONENT  = 2'd2;

   // Request kinds.
   localparam logic OP_SIGN   = 1'b0;
   localparam logic OP_VERIFY = 1'b1;

   // Reset value of the modulus.
   localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(2);

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_GO     = 5'b00100,
      ST_WAIT   = 5'b01000,
      ST_FINISH = 5'b10000
   } rsamv_state_type;

endpackage

`default_nettype wire

// ===== design/rsamv_modmul.sv =====
// Bit-serial modular multiplier: add-and-double, one multiplier bit per cycle.
`default_nettype none
`include "rsa_modexp_sign_verify_unit_defines.svh"

module rsamv_modmul
   import rsamv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [OPW-1:0] x_in_val,
   input  wire logic [OPW-1:0] y_in_val,
   input  wire logic [OPW-1:0] n_val,
   output logic                done,
   output logic [OPW-1:0]      product
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OPW-1:0]   acc_ff, acc_in;
   logic [OPW-1:0]   a_ff, a_in;
   logic [OPW-1:0]   y_ff, y_in;

   logic [OPW:0]     acc_sum, acc_dif;
   logic [OPW:0]     a_sum, a_dif;
   logic [OPW-1:0]   acc_red, a_red;

   // Modular add of the addend and doubling of the addend, both below n.
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, a_ff};
      acc_dif = acc_sum - {1'b0, n_val};
      acc_red = (acc_sum >= {1'b0, n_val}) ? acc_dif[OPW-1:0] : acc_sum[OPW-1:0];
      a_sum   = {a_ff, 1'b0};
      a_dif   = a_sum - {1'b0, n_val};
      a_red   = (a_sum >= {1'b0, n_val}) ? a_dif[OPW-1:0] : a_sum[OPW-1:0];
   end

   // Load operands on start, then consume one multiplier bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(OPW);
         acc_in  = '0;
         a_in    = x_in_val;
         y_in    = y_in_val;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            acc_in = acc_red;
         end
         a_in    = a_red;
         y_in    = y_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   `RSAMV_ASSERT_IMP(a_mm_no_restart, clock, reset, start, !busy_ff, "modmul started while busy")
   `RSAMV_ASSERT_IMP(a_mm_reduced, clock, reset, busy_ff, (acc_ff < n_val) && (a_ff < n_val), "modmul operand not reduced")
   `RSAMV_ASSERT_NXT(a_mm_done_last, clock, reset, busy_ff && (cnt_ff == CNT_W'(1)), done_ff && !busy_ff, "modmul missed done")

endmodule

`default_nettype wire

// ===== design/rsa_modexp_sign_verify_unit.sv =====
// RSA sign/verify unit: right-to-left square-and-multiply over bit-serial multipliers.
//
// Usage: write the modulus, private exponent and public exponent through the
// csr_ port while no request is in flight. A request on req_ (op 0 = sign the
// message, op 1 = verify the signature against the message) is taken when
// req_valid and req_ready are high; one response per request appears on rsp_
// and is held until rsp_ready.
// A sign request whose message is not below the modulus, or any request with a
// modulus below 2, is answered from the finish state without the multipliers.
// Otherwise the base is first reduced mod n by one multiplier pass, then each of
// the OPW exponent bits takes a start state, OPW multiplier steps and a done.
// Two bit-serial multipliers run in lockstep per exponent bit (product and
// square); their OPW-step add-and-double loop sets the rate. One request is in
// work at a time; req_ready rises again as soon as the result is in the
// output register, so the next request can start while that response waits.
// Stall: if rsp_ready stays low, the finished result waits in the sequencer
// until the output register frees up.
// Reset: clears the sequencer and the response valid, modulus to 2, exponents 0.
`default_nettype none
`include "rsa_modexp_sign_verify_unit_defines.svh"

module rsa_modexp_sign_verify_unit
   import rsamv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write_en,
   input  wire logic [CSR_W-1:0]   csr_index,
   input  wire logic [FIELD_W-1:0] csr_wdata,
   // requests
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic [FIELD_W-1:0] req_message,
   input  wire logic [FIELD_W-1:0] req_signature,
   // responses
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [FIELD_W-1:0]      rsp_result_value,
   output logic                    rsp_signature_valid,
   output logic                    rsp_range_error
);

   // Configuration registers.
   logic [FIELD_W-1:0] modulus_ff;
   logic [FIELD_W-1:0] priv_exp_ff;
   logic [FIELD_W-1:0] pub_exp_ff;

   rsamv_state_type    state_ff, state_in;
   logic [CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [OPW-1:0]     exp_ff, exp_in;
   logic [OPW-1:0]     acc_ff, acc_in;
   logic [OPW-1:0]     base_ff, base_in;
   logic [OPW-1:0]     msg_ff, msg_in;
   logic               op_ff, op_in;
   logic               err_ff, err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [OPW-1:0]     rsp_value_ff, rsp_value_in;
   logic               rsp_sigok_ff, rsp_sigok_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [OPW-1:0]     n_val;
   logic [OPW-1:0]     req_msg_w;
   logic [OPW-1:0]     req_base_w;
   logic               req_acc;
   logic               rsp_free;

   logic               mul_start, sq_start;
   logic [OPW-1:0]     mul_x, mul_y;
   logic               mul_done, sq_done;
   logic [OPW-1:0]     mul_prod, sq_prod;

   assign n_val      = modulus_ff[OPW-1:0];
   assign req_msg_w  = req_message[OPW-1:0];
   assign req_base_w = (req_op == OP_VERIFY) ? req_signature[OPW-1:0] : req_message[OPW-1:0];
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Write configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MODULUS_RESET;
         priv_exp_ff <= '0;
         pub_exp_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODULUS:          modulus_ff  <= csr_wdata;
            CSR_PRIVATE_EXPONENT: priv_exp_ff <= csr_wdata;
            CSR_PUBLIC_EXPONENT:  pub_exp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Feed the multipliers: reduction uses 1 * base, exponent steps use acc * b and b * b.
   always_comb begin
      mul_x     = acc_ff;
      mul_y     = base_ff;
      mul_start = 1'b0;
      sq_start  = (state_ff == ST_GO);
      if (state_ff == ST_IDLE) begin
         mul_x     = OPW'(1);
         mul_y     = req_base_w;
         mul_start = req_acc && (n_val >= OPW'(2)) &&
                     !((req_op == OP_SIGN) && (req_msg_w >= n_val));
      end else if (state_ff == ST_GO) begin
         mul_start = 1'b1;
      end
   end

   rsamv_modmul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .x_in_val (mul_x),
      .y_in_val (mul_y),
      .n_val    (n_val),
      .done     (mul_done),
      .product  (mul_prod)
   );

   rsamv_modmul u_sq (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .x_in_val (base_ff),
      .y_in_val (base_ff),
      .n_val    (n_val),
      .done     (sq_done),
      .product  (sq_prod)
   );

   // Sequence one request: check, reduce, step through exponent bits, hand off.
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      msg_in       = msg_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_sigok_in = rsp_sigok_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in  = req_op;
               msg_in = req_msg_w;
               exp_in = (req_op == OP_VERIFY) ? pub_exp_ff[OPW-1:0] : priv_exp_ff[OPW-1:0];
               acc_in = '0;
               err_in = (req_op == OP_SIGN) && (req_msg_w >= n_val);
               if (mul_start) begin
                  state_in = ST_REDUCE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in    = mul_prod;
               acc_in     = OPW'(1);
               bit_cnt_in = CNT_W'(OPW);
               state_in   = ST_GO;
            end
         end
         ST_GO: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               if (exp_ff[0]) begin
                  acc_in = mul_prod;
               end
               base_in    = sq_prod;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff - CNT_W'(1);
               state_in   = (bit_cnt_ff == CNT_W'(1)) ? ST_FINISH : ST_GO;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               rsp_err_in   = err_ff;
               rsp_sigok_in = (op_ff == OP_VERIFY) && (acc_ff == msg_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      msg_ff       <= msg_in;
      op_ff        <= op_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sigok_ff <= rsp_sigok_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = FIELD_W'(rsp_value_ff);
   assign rsp_signature_valid = rsp_sigok_ff;
   assign rsp_range_error     = rsp_err_ff;

   `RSAMV_ASSERT_NXT(a_top_accept_busy, clock, reset, req_acc, !req_ready, "request accepted but sequencer stayed idle")
   `RSAMV_ASSERT_IMP(a_top_lockstep, clock, reset, (state_ff == ST_WAIT) && (mul_done || sq_done), mul_done && sq_done, "multipliers out of step")
   `RSAMV_ASSERT_IMP(a_top_err_result, clock, reset, rsp_valid_ff && rsp_err_ff, (rsp_value_ff == '0) && !rsp_sigok_ff, "range error with nonzero result")

endmodule

`default_nettype wire
